// ===== design/gdad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared constants and the month length table for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

	localparam int unsigned DayW   = 5;
	localparam int unsigned MonthW = 4;
	localparam int unsigned YearW  = 14;
	localparam int unsigned AddW   = 15;
	localparam int unsigned RunW   = 16;

	localparam logic [YearW-1:0]  YearLimit = 14'd9999;
	localparam logic [MonthW-1:0] MonthJan  = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
	localparam logic [MonthW-1:0] MonthDec  = 4'd12;

	localparam logic [DayW-1:0] LastDayDec = 5'd31;
	localparam logic [DayW-1:0] FebLeapLen = 5'd29;
	localparam logic [DayW-1:0] FebLen     = 5'd28;

	// Days in each month of a common year, January first.
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
		logic [DayW-1:0] len;
		case (month)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== design/gdad_month_len.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_month_len
// Length of the current month, with the leap year rule applied to February.
// ----------------------------------------------------------------------------
module gdad_month_len (
	input  logic [gdad_pkg::MonthW-1:0] month,
	input  logic [1:0]                  year_lsb,
	input  logic [8:0]                  year_mod400,
	input  logic [8:0]                  year_mod100,
	output logic [gdad_pkg::DayW-1:0]   len
);

	logic leap;

	// Divisible by 400, or by 4 but not by 100.
	assign leap = (year_mod400 == 9'd0) || ((year_lsb == 2'd0) && (year_mod100 != 9'd0));

	always_comb begin
		if (month == gdad_pkg::MonthFeb) begin
			len = leap ? gdad_pkg::FebLeapLen : gdad_pkg::FebLen;
		end else begin
			len = gdad_pkg::month_len(month);
		end
	end

endmodule

// ===== design/gregorian_date_add_days_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Adds a day count to a Gregorian date by walking one month per cycle.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The result appears on
// the end_* ports with done high for exactly one cycle and must be captured
// then, since the block cannot be stalled. A bad month, or a start year above
// 9999, has done high in the cycle right after the item is taken. Otherwise
// the block first reduces the year modulo 400 and 100 by repeated subtraction,
// then walks one month per cycle through a single shared subtractor until the
// remaining day count fits in the current month. busy stays high until the
// result is shown.
module gregorian_date_add_days_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [gdad_pkg::DayW-1:0]    start_day,
	input  logic [gdad_pkg::MonthW-1:0]  start_month,
	input  logic [gdad_pkg::YearW-1:0]   start_year,
	input  logic [gdad_pkg::AddW-1:0]    days_to_add,
	output logic                         done,
	output logic [gdad_pkg::DayW-1:0]    end_day,
	output logic [gdad_pkg::MonthW-1:0]  end_month,
	output logic [gdad_pkg::YearW-1:0]   end_year,
	output logic                         year_overflow,
	output logic                         bad_month
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD400,
		ST_MOD100,
		ST_WALK
	} state_t;

	state_t                       state_q;
	logic [gdad_pkg::RunW-1:0]    run_q;
	logic [gdad_pkg::MonthW-1:0]  month_q;
	logic [gdad_pkg::YearW-1:0]   year_q;
	logic [gdad_pkg::YearW-1:0]   r400_q;
	logic [8:0]                   r100_q;

	logic [gdad_pkg::DayW-1:0]    len;
	logic [gdad_pkg::RunW-1:0]    sub_a;
	logic [gdad_pkg::RunW-1:0]    sub_b;
	logic [gdad_pkg::RunW:0]      diff;
	logic                         borrow;
	logic                         month_bad;

	gdad_month_len u_month_len (
		.month       (month_q),
		.year_lsb    (year_q[1:0]),
		.year_mod400 (r400_q[8:0]),
		.year_mod100 (r100_q),
		.len         (len)
	);

	// The one subtractor is shared by the modulo reduction and the month walk.
	always_comb begin
		case (state_q)
			ST_MOD400: begin
				sub_a = {{(gdad_pkg::RunW - gdad_pkg::YearW){1'b0}}, r400_q};
				sub_b = 16'd400;
			end
			ST_MOD100: begin
				sub_a = {7'd0, r100_q};
				sub_b = 16'd100;
			end
			default: begin
				sub_a = run_q;
				sub_b = {{(gdad_pkg::RunW - gdad_pkg::DayW){1'b0}}, len};
			end
		endcase
	end

	assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow    = diff[gdad_pkg::RunW];
	assign month_bad = (start_month < gdad_pkg::MonthJan) || (start_month > gdad_pkg::MonthDec);
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done          <= 1'b0;
			run_q         <= '0;
			month_q       <= '0;
			year_q        <= '0;
			r400_q        <= '0;
			r100_q        <= '0;
			end_day       <= '0;
			end_month     <= '0;
			end_year      <= '0;
			year_overflow <= 1'b0;
			bad_month     <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						run_q   <= {{(gdad_pkg::RunW - gdad_pkg::DayW){1'b0}}, start_day}
						         + {{(gdad_pkg::RunW - gdad_pkg::AddW){1'b0}}, days_to_add};
						month_q <= start_month;
						year_q  <= start_year;
						r400_q  <= start_year;
						if (month_bad) begin
							end_day       <= '0;
							end_month     <= '0;
							end_year      <= start_year;
							year_overflow <= 1'b0;
							bad_month     <= 1'b1;
							done          <= 1'b1;
						end else if (start_year > gdad_pkg::YearLimit) begin
							end_day       <= gdad_pkg::LastDayDec;
							end_month     <= gdad_pkg::MonthDec;
							end_year      <= gdad_pkg::YearLimit;
							year_overflow <= 1'b1;
							bad_month     <= 1'b0;
							done          <= 1'b1;
						end else begin
							state_q <= ST_MOD400;
						end
					end
				end
				ST_MOD400: begin
					// Subtracting 400 until it would go negative leaves the year modulo 400.
					if (!borrow) begin
						r400_q <= diff[gdad_pkg::YearW-1:0];
					end else begin
						r100_q  <= r400_q[8:0];
						state_q <= ST_MOD100;
					end
				end
				ST_MOD100: begin
					if (!borrow) begin
						r100_q <= diff[8:0];
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (borrow || (diff == '0)) begin
						end_day       <= run_q[gdad_pkg::DayW-1:0];
						end_month     <= month_q;
						end_year      <= year_q;
						year_overflow <= 1'b0;
						bad_month     <= 1'b0;
						done          <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						run_q <= diff[gdad_pkg::RunW-1:0];
						if (month_q >= gdad_pkg::MonthDec) begin
							month_q <= gdad_pkg::MonthJan;
							if (year_q >= gdad_pkg::YearLimit) begin
								end_day       <= gdad_pkg::LastDayDec;
								end_month     <= gdad_pkg::MonthDec;
								end_year      <= gdad_pkg::YearLimit;
								year_overflow <= 1'b1;
								bad_month     <= 1'b0;
								done          <= 1'b1;
								state_q       <= ST_IDLE;
							end else begin
								year_q <= year_q + 14'd1;
								r400_q <= (r400_q == 14'd399) ? 14'd0 : r400_q + 14'd1;
								r100_q <= (r100_q == 9'd99) ? 9'd0 : r100_q + 9'd1;
							end
						end else begin
							month_q <= month_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
